>>> src/oqhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order queue package
// Shared record layout, command and status codes, and default sizes.
// ----------------------------------------------------------------------------
package oqhs_pkg;

  localparam int DEPTH_DEF = 128;

  localparam int ID_W    = 24;
  localparam int TAG_W   = 16;
  localparam int PRICE_W = 19;
  localparam int PIN_W   = 20;

  typedef enum logic [1:0] {
    FN_PLACE  = 2'd0,
    FN_SERVE  = 2'd1,
    FN_CANCEL = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_QFULL    = 3'd1,
    ST_QEMPTY   = 3'd2,
    ST_HEMPTY   = 3'd3,
    ST_BADPRICE = 3'd4
  } status_t;

  // One stored order record, as kept in both memories.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TAG_W-1:0]   customer;
    logic [TAG_W-1:0]   item;
    logic [PRICE_W-1:0] price;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

>>> src/oqhs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oqhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/order_queue_with_history_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order queue with history stack
// Linear pending queue of order records plus a LIFO history of served ones.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel carries one command word per handshake: place an order,
// serve the head of the queue, or cancel the last served order. Each place,
// serve and cancel returns exactly one result word on the output channel;
// the unused command code is consumed and returns nothing.
// A place command, and any command that ends in an error status, shows its
// result in the cycle after acceptance, so places can stream at one per cycle
// while the receiver does not stall. Serve and cancel read a record memory
// with registered read data and present their result from the output
// register; no new command is taken while that read is in progress.
// Records live in two synchronous memories (queue and history) of DEPTH
// entries each; the memories are never cleared, and only the pointers,
// counters, state and output valid flag are reset. After reset the queue and
// the history are empty and the next order id is one.
// The result is held in an output register. While the receiver stalls, the
// result stays put and new commands are stalled once that register is full.
// ----------------------------------------------------------------------------
module order_queue_with_history_stack_top
  import oqhs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [TAG_W-1:0]   in_customer_tag,
  input  logic [TAG_W-1:0]   in_item_tag,
  input  logic [PIN_W-1:0]   in_price_cents,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_history_dropped,
  output logic [ID_W-1:0]    out_order_id,
  output logic [TAG_W-1:0]   out_customer,
  output logic [TAG_W-1:0]   out_item,
  output logic [PRICE_W-1:0] out_price
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SERVE,
    S_CANCEL
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    pend_r, pend_nxt;
  logic [CW-1:0]    hcnt_r, hcnt_nxt;
  logic [ID_W-1:0]  next_id_r, next_id_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic             drop_r, drop_nxt;
  rec_t             out_rec_r, out_rec_nxt;

  logic             accept;
  logic             out_take;
  logic [CW-1:0]    hcnt_dec;
  rec_t             in_rec;

  logic             q_we, q_re, h_we, h_re;
  logic [AW-1:0]    q_waddr, q_raddr, h_waddr, h_raddr;
  rec_t             q_wdata, h_wdata, q_rdata, h_rdata;

  // The block takes a command only between memory accesses and when the
  // output register is free or being emptied in this cycle. That also keeps
  // every memory write at an earlier edge than any read of the same entry.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign hcnt_dec = CW'(hcnt_r - 1'b1);

  assign in_rec.id       = next_id_r;
  assign in_rec.customer = in_customer_tag;
  assign in_rec.item     = in_item_tag;
  assign in_rec.price    = in_price_cents[PRICE_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    pend_nxt      = pend_r;
    hcnt_nxt      = hcnt_r;
    next_id_nxt   = next_id_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    status_nxt    = status_r;
    drop_nxt      = drop_r;
    out_rec_nxt   = out_rec_r;
    q_we          = 1'b0;
    q_re          = 1'b0;
    h_we          = 1'b0;
    h_re          = 1'b0;
    q_waddr       = tail_r[AW-1:0];
    q_raddr       = head_r[AW-1:0];
    h_waddr       = hcnt_r[AW-1:0];
    h_raddr       = hcnt_dec[AW-1:0];
    q_wdata       = in_rec;
    h_wdata       = q_rdata;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Error results carry all-zero payload; preset that here.
          status_nxt  = ST_OK;
          drop_nxt    = 1'b0;
          out_rec_nxt = '0;
          case (func_t'(in_func))
            FN_PLACE: begin
              out_valid_nxt = 1'b1;
              if (in_price_cents[PIN_W-1]) begin
                status_nxt = ST_BADPRICE;
              end else if (tail_r == DEPTH_C) begin
                status_nxt = ST_QFULL;
              end else begin
                q_we        = 1'b1;
                tail_nxt    = CW'(tail_r + 1'b1);
                pend_nxt    = CW'(pend_r + 1'b1);
                next_id_nxt = next_id_r + 1'b1;
                out_rec_nxt = in_rec;
              end
            end
            FN_SERVE: begin
              if (pend_r == '0) begin
                status_nxt    = ST_QEMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                q_re     = 1'b1;
                pend_nxt = CW'(pend_r - 1'b1);
                // The queue is linear: both pointers rewind once it drains.
                if (pend_r == CW'(1)) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end else begin
                  head_nxt = CW'(head_r + 1'b1);
                end
                state_nxt = S_SERVE;
              end
            end
            FN_CANCEL: begin
              if (hcnt_r == '0) begin
                status_nxt    = ST_HEMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                h_re      = 1'b1;
                hcnt_nxt  = hcnt_dec;
                state_nxt = S_CANCEL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SERVE: begin
        // Push the served record onto the history unless it is full.
        if (hcnt_r != DEPTH_C) begin
          h_we     = 1'b1;
          hcnt_nxt = CW'(hcnt_r + 1'b1);
          drop_nxt = 1'b0;
        end else begin
          drop_nxt = 1'b1;
        end
        out_rec_nxt   = q_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CANCEL: begin
        out_rec_nxt   = h_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    drop_r    <= drop_nxt;
    out_rec_r <= out_rec_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      pend_r      <= '0;
      hcnt_r      <= '0;
      next_id_r   <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      pend_r      <= pend_nxt;
      hcnt_r      <= hcnt_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  oqhs_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_en   (q_re),
    .rd_addr (q_raddr),
    .rd_data (q_rdata)
  );

  oqhs_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (h_we),
    .wr_addr (h_waddr),
    .wr_data (h_wdata),
    .rd_en   (h_re),
    .rd_addr (h_raddr),
    .rd_data (h_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_history_dropped = drop_r;
  assign out_order_id        = out_rec_r.id;
  assign out_customer        = out_rec_r.customer;
  assign out_item            = out_rec_r.item;
  assign out_price           = out_rec_r.price;

endmodule
